@@ src/bst_pkg.sv @@
// ----------------------------------------------------------------------------
// bst_pkg: shared definitions of the bencode stream tokenizer
// Event, type, error and parser mode codes, character constants and the
// result word that travels through the result queue.
// ----------------------------------------------------------------------------
package bst_pkg;

	localparam logic [1:0] EV_OPEN  = 2'd0;
	localparam logic [1:0] EV_BYTE  = 2'd1;
	localparam logic [1:0] EV_DONE  = 2'd2;
	localparam logic [1:0] EV_ERROR = 2'd3;

	localparam logic [1:0] TY_INT  = 2'd0;
	localparam logic [1:0] TY_STR  = 2'd1;
	localparam logic [1:0] TY_LIST = 2'd2;
	localparam logic [1:0] TY_DICT = 2'd3;

	localparam logic [2:0] ERR_UNKNOWN = 3'd0;
	localparam logic [2:0] ERR_KEY     = 3'd1;
	localparam logic [2:0] ERR_INT     = 3'd2;
	localparam logic [2:0] ERR_LEN     = 3'd3;
	localparam logic [2:0] ERR_DEEP    = 3'd4;
	localparam logic [2:0] ERR_NONE    = 3'd0;

	localparam logic [2:0] MODE_FIELD   = 3'd0;
	localparam logic [2:0] MODE_INT     = 3'd1;
	localparam logic [2:0] MODE_STRLEN  = 3'd2;
	localparam logic [2:0] MODE_STRBODY = 3'd3;
	localparam logic [2:0] MODE_ERROR   = 3'd4;

	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic [1:0]         event_res;
		logic [1:0]         object_type;
		logic [4:0]         nest_level;
		logic [31:0]        start_offset;
		logic [31:0]        content_offset;
		logic [31:0]        total_length;
		logic [31:0]        content_length;
		logic signed [63:0] number;
		logic [2:0]         error_code;
		logic               is_key;
		logic               last;
	} result_t;

endpackage

@@ src/bst_if.sv @@
// ----------------------------------------------------------------------------
// bst_if: stream channels of the bencode stream tokenizer
// Byte channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface bst_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface bst_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         event_res;
	logic [1:0]         object_type;
	logic [4:0]         nest_level;
	logic [31:0]        start_offset;
	logic [31:0]        content_offset;
	logic [31:0]        total_length;
	logic [31:0]        content_length;
	logic signed [63:0] number;
	logic [2:0]         error_code;
	logic               is_key;
	logic               last;
	modport source (output valid, output event_res, output object_type, output nest_level,
		output start_offset, output content_offset, output total_length,
		output content_length, output number, output error_code, output is_key,
		output last, input ready);
	modport sink (input valid, input event_res, input object_type, input nest_level,
		input start_offset, input content_offset, input total_length,
		input content_length, input number, input error_code, input is_key,
		input last, output ready);
endinterface

@@ src/bst_res_fifo.sv @@
// ----------------------------------------------------------------------------
// bst_res_fifo: four-word result queue
// Takes up to two words per cycle, hands out one. It signals room when at
// least two words are free, so a byte is never accepted without space.
// ----------------------------------------------------------------------------
module bst_res_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push0,
	input  logic              push1,
	input  bst_pkg::result_t  wr0,
	input  bst_pkg::result_t  wr1,
	output logic              room,
	output logic              rd_valid,
	input  logic              rd_ready,
	output bst_pkg::result_t  rd_word
);
	localparam int DEPTH = 4;
	localparam int PW = $clog2(DEPTH);

	bst_pkg::result_t mem_q [DEPTH];
	logic [PW-1:0] head_q, tail_q;
	logic [PW:0]   cnt_q;
	logic          pop;
	logic [PW:0]   npush;

	assign pop      = rd_valid && rd_ready;
	assign rd_valid = cnt_q != '0;
	assign rd_word  = mem_q[head_q];
	assign room     = cnt_q <= (PW+1)'(DEPTH - 2);
	assign npush    = (PW+1)'(push0) + (PW+1)'(push1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (pop) head_q <= head_q + 1'b1;
			tail_q <= tail_q + npush[PW-1:0];
			cnt_q  <= cnt_q + npush - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push0) mem_q[tail_q] <= wr0;
		if (push1) mem_q[tail_q + 1'b1] <= wr1;
	end
endmodule

@@ src/bencode_stream_tokenizer.sv @@
// ----------------------------------------------------------------------------
// bencode_stream_tokenizer: streaming bencode tokenizer
// Parses one document byte per word and emits open, string byte, completion
// and error words.
// ----------------------------------------------------------------------------
// The block accepts one document byte per clock cycle. Each byte is parsed in
// the cycle it is accepted: the parser state, the byte offset and the nesting
// stack (held in flip-flops, one entry per open container) update at once, and
// the zero, one or two result words the byte causes go into a four-word result
// queue. A byte is taken whenever the queue has two free words, so with the
// result side always ready the block sustains one byte per cycle; the only
// stall comes from the result side holding ready low. A string content byte
// that ends its string yields two words, the second flagged last. After the
// first error word the block emits nothing more until reset.
module bencode_stream_tokenizer #(
	parameter int MAX_DEPTH   = 16,
	parameter int OFFSET_BITS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	bst_byte_if.sink data_in,
	bst_res_if.source result
);
	localparam int OW = OFFSET_BITS;
	localparam int DW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int CW = $clog2(MAX_DEPTH + 1);

	logic [2:0]    mode_q, mode_n;
	logic [OW-1:0] ofs_q;
	logic [CW-1:0] depth_q, depth_n;
	logic [MAX_DEPTH-1:0] is_dict_q, expkey_q;
	logic [OW-1:0] lvl_start_q [MAX_DEPTH];
	logic [OW-1:0] obj_start_q, obj_start_n, cont_q, cont_n;
	logic [63:0]   acc_q, acc_n;
	logic          neg_q, neg_n, dig_q, dig_n;
	logic [31:0]   rem_q, rem_n;

	logic          fire, room;
	logic [7:0]    b;
	logic [DW-1:0] top_idx, cd_idx;
	logic          has_top, top_dict, top_key, keypos, is_dig;
	logic [3:0]    dval;
	logic [67:0]   acc_x10;
	logic [63:0]   lim;
	logic [35:0]   rem_x10;
	logic [OW-1:0] ofs1, top_start;
	logic          push_en, cd_en;
	logic          p0, p1;
	bst_pkg::result_t r0, r1, rd;

	assign fire = data_in.valid && data_in.ready;
	assign data_in.ready = room;
	assign b = data_in.data_byte;

	assign has_top   = depth_q != '0;
	assign top_idx   = DW'(depth_q - 1'b1);
	assign top_dict  = is_dict_q[top_idx];
	assign top_key   = expkey_q[top_idx];
	assign top_start = lvl_start_q[top_idx];
	assign keypos    = has_top && top_dict && top_key;
	assign is_dig    = b >= bst_pkg::CH_ZERO && b <= bst_pkg::CH_NINE;
	assign dval      = 4'(b - bst_pkg::CH_ZERO);
	assign ofs1      = ofs_q + 1'b1;
	// Overflow tests compare ten times the value plus the digit to the limit.
	assign acc_x10   = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 68'(dval);
	assign lim       = neg_q ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
	assign rem_x10   = ({4'b0, rem_q} << 3) + ({4'b0, rem_q} << 1) + 36'(dval);

	function automatic bst_pkg::result_t mk(logic [1:0] ev, logic [1:0] ty,
		logic [CW-1:0] lv, logic [OW-1:0] st, logic [OW-1:0] co,
		logic [OW-1:0] tot, logic [OW-1:0] cl, logic [63:0] num,
		logic [2:0] err, logic key);
		bst_pkg::result_t w;
		w.event_res      = ev;
		w.object_type    = ty;
		w.nest_level     = 5'(lv);
		w.start_offset   = 32'(st);
		w.content_offset = 32'(co);
		w.total_length   = 32'(tot);
		w.content_length = 32'(cl);
		w.number         = num;
		w.error_code     = err;
		w.is_key         = key;
		w.last           = 1'b1;
		return w;
	endfunction

	always_comb begin
		mode_n = mode_q; depth_n = depth_q; obj_start_n = obj_start_q; cont_n = cont_q;
		acc_n = acc_q; neg_n = neg_q; dig_n = dig_q; rem_n = rem_q;
		push_en = 1'b0; cd_en = 1'b0; p0 = 1'b0; p1 = 1'b0;
		r0 = mk(bst_pkg::EV_ERROR, bst_pkg::TY_INT, depth_q, ofs_q, '0, '0, '0, '0,
			bst_pkg::ERR_UNKNOWN, 1'b0);
		r1 = r0;
		unique case (mode_q)
			bst_pkg::MODE_FIELD: begin
				if (b == bst_pkg::CH_E && has_top && !(top_dict && !top_key)) begin
					depth_n = depth_q - 1'b1;
					p0 = 1'b1; cd_en = 1'b1;
					r0 = mk(bst_pkg::EV_DONE, top_dict ? bst_pkg::TY_DICT : bst_pkg::TY_LIST,
						depth_n, top_start, top_start + 1'b1, ofs1 - top_start,
						ofs_q - top_start - 1'b1, '0, bst_pkg::ERR_NONE, 1'b0);
				end else if (b == bst_pkg::CH_D || b == bst_pkg::CH_L || b == bst_pkg::CH_I) begin
					if (keypos) begin
						p0 = 1'b1; r0.error_code = bst_pkg::ERR_KEY;
					end else if (b == bst_pkg::CH_I) begin
						mode_n = bst_pkg::MODE_INT; obj_start_n = ofs_q; cont_n = ofs1;
						acc_n = '0; neg_n = 1'b0; dig_n = 1'b0;
					end else if (depth_q >= CW'(MAX_DEPTH)) begin
						p0 = 1'b1; r0.error_code = bst_pkg::ERR_DEEP;
					end else begin
						push_en = 1'b1; depth_n = depth_q + 1'b1; p0 = 1'b1;
						r0 = mk(bst_pkg::EV_OPEN,
							(b == bst_pkg::CH_D) ? bst_pkg::TY_DICT : bst_pkg::TY_LIST,
							depth_q, ofs_q, ofs1, '0, '0, '0, bst_pkg::ERR_NONE, 1'b0);
					end
				end else if (is_dig) begin
					mode_n = bst_pkg::MODE_STRLEN; obj_start_n = ofs_q; rem_n = 32'(dval);
				end else begin
					p0 = 1'b1;
				end
			end
			bst_pkg::MODE_INT: begin
				if (b == bst_pkg::CH_E) begin
					if (!dig_q || (neg_q && acc_q == '0)) begin
						p0 = 1'b1; r0.error_code = bst_pkg::ERR_INT;
					end else begin
						mode_n = bst_pkg::MODE_FIELD; p0 = 1'b1; cd_en = 1'b1;
						r0 = mk(bst_pkg::EV_DONE, bst_pkg::TY_INT, depth_q, obj_start_q, cont_q,
							ofs1 - obj_start_q, ofs_q - cont_q, neg_q ? (64'd0 - acc_q) : acc_q,
							bst_pkg::ERR_NONE, 1'b0);
					end
				end else if (b == bst_pkg::CH_MINUS && !neg_q && !dig_q) begin
					neg_n = 1'b1;
				end else if (is_dig) begin
					if ((dig_q && acc_q == '0) || acc_x10 > {4'b0, lim}) begin
						p0 = 1'b1; r0.error_code = bst_pkg::ERR_INT;
					end else begin
						acc_n = acc_x10[63:0]; dig_n = 1'b1;
					end
				end else begin
					p0 = 1'b1; r0.error_code = bst_pkg::ERR_INT;
				end
			end
			bst_pkg::MODE_STRLEN: begin
				if (b == bst_pkg::CH_COLON) begin
					cont_n = ofs1;
					if (rem_q == '0) begin
						mode_n = bst_pkg::MODE_FIELD; p0 = 1'b1; cd_en = 1'b1;
						r0 = mk(bst_pkg::EV_DONE, bst_pkg::TY_STR, depth_q, obj_start_q, ofs1,
							ofs1 - obj_start_q, '0, '0, bst_pkg::ERR_NONE, keypos);
					end else begin
						mode_n = bst_pkg::MODE_STRBODY;
					end
				end else if (is_dig && rem_x10[35:32] == '0) begin
					rem_n = rem_x10[31:0];
				end else begin
					p0 = 1'b1; r0.error_code = bst_pkg::ERR_LEN;
				end
			end
			bst_pkg::MODE_STRBODY: begin
				p0 = 1'b1;
				rem_n = rem_q - 1'b1;
				r0 = mk(bst_pkg::EV_BYTE, bst_pkg::TY_STR, depth_q, obj_start_q, cont_q,
					'0, '0, 64'(b), bst_pkg::ERR_NONE, keypos);
				if (rem_n == '0) begin
					mode_n = bst_pkg::MODE_FIELD; p1 = 1'b1; cd_en = 1'b1;
					r0.last = 1'b0;
					r1 = mk(bst_pkg::EV_DONE, bst_pkg::TY_STR, depth_q, obj_start_q, cont_q,
						ofs1 - obj_start_q, ofs1 - cont_q, '0, bst_pkg::ERR_NONE, keypos);
				end
			end
			default: begin
			end
		endcase
		if (p0 && r0.event_res == bst_pkg::EV_ERROR) mode_n = bst_pkg::MODE_ERROR;
	end

	// A dictionary parent of a finished child flips between key and value position.
	assign cd_idx = DW'(depth_n - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bst_pkg::MODE_FIELD; ofs_q <= '0; depth_q <= '0;
			obj_start_q <= '0; cont_q <= '0; acc_q <= '0;
			neg_q <= 1'b0; dig_q <= 1'b0; rem_q <= '0;
		end else if (fire && mode_q != bst_pkg::MODE_ERROR) begin
			mode_q <= mode_n; ofs_q <= ofs1; depth_q <= depth_n;
			obj_start_q <= obj_start_n; cont_q <= cont_n; acc_q <= acc_n;
			neg_q <= neg_n; dig_q <= dig_n; rem_q <= rem_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && mode_q != bst_pkg::MODE_ERROR) begin
			if (push_en) begin
				is_dict_q[DW'(depth_q)]   <= (b == bst_pkg::CH_D);
				expkey_q[DW'(depth_q)]    <= (b == bst_pkg::CH_D);
				lvl_start_q[DW'(depth_q)] <= ofs_q;
			end
			if (cd_en && depth_n != '0 && is_dict_q[cd_idx])
				expkey_q[cd_idx] <= !expkey_q[cd_idx];
		end
	end

	bst_res_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push0(fire && p0), .push1(fire && p1), .wr0(r0), .wr1(r1),
		.room(room), .rd_valid(result.valid), .rd_ready(result.ready), .rd_word(rd)
	);

	assign result.event_res      = rd.event_res;
	assign result.object_type    = rd.object_type;
	assign result.nest_level     = rd.nest_level;
	assign result.start_offset   = rd.start_offset;
	assign result.content_offset = rd.content_offset;
	assign result.total_length   = rd.total_length;
	assign result.content_length = rd.content_length;
	assign result.number         = rd.number;
	assign result.error_code     = rd.error_code;
	assign result.is_key         = rd.is_key;
	assign result.last           = rd.last;
endmodule

@@ src/bst_checker.sv @@
// ----------------------------------------------------------------------------
// bst_checker: port-level checks of the bencode stream tokenizer
// Watches the result channel over time.
// ----------------------------------------------------------------------------
module bst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  event_res,
	input logic [2:0]  error_code,
	input logic [31:0] start_offset
);
	// A stalled result word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(start_offset) && $stable(event_res))
		else $error("result word changed while stalled");

	// Nothing follows an error word.
	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && event_res == bst_pkg::EV_ERROR |=> !out_valid)
		else $error("result after error");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != bst_pkg::EV_ERROR |-> error_code == bst_pkg::ERR_NONE)
		else $error("error code on non-error word");
endmodule

bind bencode_stream_tokenizer bst_checker u_bst_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(result.valid), .out_ready(result.ready),
	.event_res(result.event_res), .error_code(result.error_code),
	.start_offset(result.start_offset)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the bencode stream tokenizer
// A short table of hand-picked documents comes first, then a long stream of
// random well-formed bencode values, and at the very end one malformed
// construct followed by noise, since an error locks the parser until reset.
// Every accepted byte is run through a behavioral parser kept in this file,
// and every result word is compared with the oldest word it predicted.
// ----------------------------------------------------------------------------
module testbench;

	localparam int DEPTH_LIMIT = 16;
	localparam int STALL_LIMIT = 20000;
	localparam int STREAM_BYTES = 1780;

	logic clk;
	logic arst_n;

	bst_byte_if byte_ch ();
	bst_res_if  res_ch ();

	// Drivers of the channel inputs, all known from time zero.
	logic       src_valid = 1'b0;
	logic [7:0] src_byte  = 8'h00;
	logic       snk_ready = 1'b0;
	assign byte_ch.valid     = src_valid;
	assign byte_ch.data_byte = src_byte;
	assign res_ch.ready      = snk_ready;

	bencode_stream_tokenizer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.data_in(byte_ch),
		.result (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Idle rates of the current phase, in percent.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// Expected result words, oldest first.
	bst_pkg::result_t pending_words[$];
	int      mismatch_count = 0;
	int      quiet_cycles = 0;

	// ------------------------------------------------------------------------
	// Behavioral parser: its own copy of the tokenizer state.
	// ------------------------------------------------------------------------
	logic [2:0]  p_mode;
	logic [31:0] p_ofs;
	int          p_depth;
	logic        p_is_dict [DEPTH_LIMIT];
	logic        p_want_key [DEPTH_LIMIT];
	logic [31:0] p_lvl_start [DEPTH_LIMIT];
	logic [31:0] p_obj_start;
	logic [31:0] p_body_start;
	logic [63:0] p_acc;
	logic        p_neg;
	logic        p_digit;
	logic [31:0] p_remaining;

	function automatic bst_pkg::result_t mk(logic [1:0] ev, logic [1:0] ty, int lvl,
			logic [31:0] st, logic [31:0] co, logic [31:0] tot, logic [31:0] cl,
			logic [63:0] num, logic [2:0] err, logic key, logic lst);
		bst_pkg::result_t w;
		w.event_res      = ev;
		w.object_type    = ty;
		w.nest_level     = lvl[4:0];
		w.start_offset   = st;
		w.content_offset = co;
		w.total_length   = tot;
		w.content_length = cl;
		w.number         = num;
		w.error_code     = err;
		w.is_key         = key;
		w.last           = lst;
		return w;
	endfunction

	function automatic bst_pkg::result_t err_word(logic [2:0] code, logic [31:0] ofs);
		return mk(bst_pkg::EV_ERROR, bst_pkg::TY_INT, p_depth, ofs, 0, 0, 0, 0, code, 0, 0);
	endfunction

	function automatic logic at_key_slot();
		if (p_depth == 0) return 1'b0;
		return p_is_dict[p_depth-1] && p_want_key[p_depth-1];
	endfunction

	// A finished child flips a dictionary between key and value position.
	function automatic void child_finished();
		if (p_depth > 0 && p_is_dict[p_depth-1])
			p_want_key[p_depth-1] = !p_want_key[p_depth-1];
	endfunction

	function automatic void parser_reset();
		p_mode = bst_pkg::MODE_FIELD;
		p_ofs = '0;
		p_depth = 0;
		p_obj_start = '0;
		p_body_start = '0;
		p_acc = '0;
		p_neg = 1'b0;
		p_digit = 1'b0;
		p_remaining = '0;
	endfunction

	// Works out the words caused by one byte; n is how many (0..2).
	function automatic void parse_byte(input logic [7:0] b, output bst_pkg::result_t w[2],
			output int n);
		logic [31:0] ofs;
		logic [63:0] dv;
		logic [63:0] lim;
		logic        key;
		logic        is_dig;
		ofs = p_ofs;
		n = 0;
		w[0] = '0;
		w[1] = '0;
		is_dig = b >= bst_pkg::CH_ZERO && b <= bst_pkg::CH_NINE;
		if (p_mode == bst_pkg::MODE_ERROR) return;
		case (p_mode)
			bst_pkg::MODE_FIELD: begin
				if (b == bst_pkg::CH_E && p_depth > 0 &&
						!(p_is_dict[p_depth-1] && !p_want_key[p_depth-1])) begin
					int lv;
					lv = p_depth - 1;
					p_depth = lv;
					w[0] = mk(bst_pkg::EV_DONE,
						p_is_dict[lv] ? bst_pkg::TY_DICT : bst_pkg::TY_LIST, lv,
						p_lvl_start[lv], p_lvl_start[lv] + 1, ofs + 1 - p_lvl_start[lv],
						ofs - p_lvl_start[lv] - 1, '0, bst_pkg::ERR_NONE, 1'b0, 1'b0);
					n = 1;
					child_finished();
				end else if (b == bst_pkg::CH_D || b == bst_pkg::CH_L ||
						b == bst_pkg::CH_I) begin
					if (at_key_slot()) begin
						w[0] = err_word(bst_pkg::ERR_KEY, ofs);
						n = 1;
						p_mode = bst_pkg::MODE_ERROR;
					end else if (b == bst_pkg::CH_I) begin
						p_mode = bst_pkg::MODE_INT;
						p_obj_start = ofs;
						p_body_start = ofs + 1;
						p_acc = '0;
						p_neg = 1'b0;
						p_digit = 1'b0;
					end else if (p_depth >= DEPTH_LIMIT) begin
						w[0] = err_word(bst_pkg::ERR_DEEP, ofs);
						n = 1;
						p_mode = bst_pkg::MODE_ERROR;
					end else begin
						p_is_dict[p_depth] = (b == bst_pkg::CH_D);
						p_want_key[p_depth] = (b == bst_pkg::CH_D);
						p_lvl_start[p_depth] = ofs;
						w[0] = mk(bst_pkg::EV_OPEN,
							b == bst_pkg::CH_D ? bst_pkg::TY_DICT : bst_pkg::TY_LIST,
							p_depth, ofs, ofs + 1, 0, 0, 0, bst_pkg::ERR_NONE, 0, 0);
						n = 1;
						p_depth++;
					end
				end else if (is_dig) begin
					p_mode = bst_pkg::MODE_STRLEN;
					p_obj_start = ofs;
					p_remaining = 32'(b - bst_pkg::CH_ZERO);
				end else begin
					w[0] = err_word(bst_pkg::ERR_UNKNOWN, ofs);
					n = 1;
					p_mode = bst_pkg::MODE_ERROR;
				end
			end
			bst_pkg::MODE_INT: begin
				dv = 64'(b) - 64'(bst_pkg::CH_ZERO);
				lim = p_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
				if (b == bst_pkg::CH_E) begin
					if (!p_digit || (p_neg && p_acc == 0)) begin
						w[0] = err_word(bst_pkg::ERR_INT, ofs);
						n = 1;
						p_mode = bst_pkg::MODE_ERROR;
					end else begin
						p_mode = bst_pkg::MODE_FIELD;
						w[0] = mk(bst_pkg::EV_DONE, bst_pkg::TY_INT, p_depth, p_obj_start,
							p_body_start, ofs + 1 - p_obj_start, ofs - p_body_start,
							p_neg ? 64'd0 - p_acc : p_acc, bst_pkg::ERR_NONE, 0, 0);
						n = 1;
						child_finished();
					end
				end else if (b == bst_pkg::CH_MINUS && !p_neg && !p_digit) begin
					p_neg = 1'b1;
				end else if (is_dig) begin
					if ((p_digit && p_acc == 0) || p_acc > (lim - dv) / 10) begin
						w[0] = err_word(bst_pkg::ERR_INT, ofs);
						n = 1;
						p_mode = bst_pkg::MODE_ERROR;
					end else begin
						p_acc = p_acc * 10 + dv;
						p_digit = 1'b1;
					end
				end else begin
					w[0] = err_word(bst_pkg::ERR_INT, ofs);
					n = 1;
					p_mode = bst_pkg::MODE_ERROR;
				end
			end
			bst_pkg::MODE_STRLEN: begin
				dv = 64'(b) - 64'(bst_pkg::CH_ZERO);
				if (b == bst_pkg::CH_COLON) begin
					p_body_start = ofs + 1;
					if (p_remaining == 0) begin
						p_mode = bst_pkg::MODE_FIELD;
						w[0] = mk(bst_pkg::EV_DONE, bst_pkg::TY_STR, p_depth, p_obj_start,
							p_body_start, ofs + 1 - p_obj_start, 0, 0, bst_pkg::ERR_NONE,
							at_key_slot(), 0);
						n = 1;
						child_finished();
					end else begin
						p_mode = bst_pkg::MODE_STRBODY;
					end
				end else if (is_dig && 64'(p_remaining) <= (64'hFFFF_FFFF - dv) / 10) begin
					p_remaining = p_remaining * 10 + dv[31:0];
				end else begin
					w[0] = err_word(bst_pkg::ERR_LEN, ofs);
					n = 1;
					p_mode = bst_pkg::MODE_ERROR;
				end
			end
			default: begin
				key = at_key_slot();
				w[0] = mk(bst_pkg::EV_BYTE, bst_pkg::TY_STR, p_depth, p_obj_start,
					p_body_start, 0, 0, 64'(b), bst_pkg::ERR_NONE, key, 0);
				n = 1;
				p_remaining = p_remaining - 1;
				if (p_remaining == 0) begin
					p_mode = bst_pkg::MODE_FIELD;
					w[1] = mk(bst_pkg::EV_DONE, bst_pkg::TY_STR, p_depth, p_obj_start,
						p_body_start, ofs + 1 - p_obj_start, ofs + 1 - p_body_start, 0,
						bst_pkg::ERR_NONE, key, 0);
					n = 2;
					child_finished();
				end
			end
		endcase
		p_ofs = ofs + 1;
		if (n > 0) w[n-1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Document generation: random well-formed values into a byte queue.
	// ------------------------------------------------------------------------
	logic [7:0] doc_bytes[$];

	function automatic void add_byte(logic [7:0] v);
		doc_bytes = {doc_bytes, v};
	endfunction

	function automatic void put_text(string s);
		for (int k = 0; k < s.len(); k++) add_byte(s[k]);
	endfunction

	function automatic void gen_string();
		int len;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 7);
		// Leading zeros in a length are legal and must not change the length.
		if ($urandom_range(0, 5) == 0) put_text("0");
		put_text($sformatf("%0d:", len));
		for (int k = 0; k < len; k++) add_byte(8'($urandom_range(0, 255)));
	endfunction

	function automatic void gen_int();
		logic [63:0] v;
		logic [63:0] mag;
		case ($urandom_range(0, 7))
			0: v = 64'd0;
			1: v = 64'h8000_0000_0000_0000;
			2: v = 64'h7FFF_FFFF_FFFF_FFFF;
			3: v = 64'($urandom_range(1, 999));
			4: v = 64'd0 - 64'($urandom_range(1, 999));
			default: v = {$urandom, $urandom};
		endcase
		mag = v[63] ? 64'd0 - v : v;
		put_text(v[63] ? "i-" : "i");
		put_text($sformatf("%0d", mag));
		put_text("e");
	endfunction

	// A dive is a chain of single-child lists down to the full stack depth.
	function automatic void gen_value(int lvl, bit dive);
		int r;
		int kids;
		r = $urandom_range(0, 99);
		if (dive && lvl < DEPTH_LIMIT) begin
			put_text("l");
			gen_value(lvl + 1, 1'b1);
			put_text("e");
		end else if (lvl < DEPTH_LIMIT && r < 25) begin
			kids = $urandom_range(0, lvl < 3 ? 4 : 2);
			put_text(r < 12 ? "d" : "l");
			for (int k = 0; k < kids; k++) begin
				if (r < 12) gen_string();
				gen_value(lvl + 1, 1'b0);
			end
			put_text("e");
		end else if (r < 60) begin
			gen_int();
		end else begin
			gen_string();
		end
	endfunction

	// One malformed construct closes the stream; the parser is at top level.
	function automatic void gen_fault();
		case ($urandom_range(0, 11))
			0: put_text("x");
			1: put_text("e");
			2: put_text("di");
			3: put_text("dl");
			4: put_text("d1:ke");
			5: put_text("i-0e");
			6: put_text("i01e");
			7: put_text("i9223372036854775808e");
			8: put_text("i-e");
			9: put_text("12x");
			10: put_text("4294967296:");
			default: for (int k = 0; k <= DEPTH_LIMIT; k++) put_text("l");
		endcase
		// Noise after the error must produce no words at all.
		for (int k = 0; k < 30; k++) add_byte(8'($urandom_range(0, 255)));
	endfunction

	// ------------------------------------------------------------------------
	// Byte sender: returns right after the rising edge that took the word.
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_valid <= 1'b1;
		src_byte  <= b;
		do @(posedge clk); while (!byte_ch.ready);
	endtask

	task automatic expect_words(input bst_pkg::result_t w[2], input int n);
		for (int k = 0; k < n; k++) pending_words = {pending_words, w[k]};
	endtask

	// ------------------------------------------------------------------------
	// Result side: random stalls at the falling edge, checks at the rising.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		snk_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		bst_pkg::result_t got;
		bst_pkg::result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = mk(res_ch.event_res, res_ch.object_type, res_ch.nest_level,
				res_ch.start_offset, res_ch.content_offset, res_ch.total_length,
				res_ch.content_length, res_ch.number, res_ch.error_code,
				res_ch.is_key, res_ch.last);
			if (pending_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected word: %p", got);
			end else begin
				want = pending_words.pop_front();
				if (got.event_res != want.event_res || got.object_type != want.object_type ||
						got.nest_level != want.nest_level ||
						got.start_offset != want.start_offset ||
						got.content_offset != want.content_offset ||
						got.total_length != want.total_length ||
						got.content_length != want.content_length ||
						got.number != want.number || got.error_code != want.error_code ||
						got.is_key != want.is_key || got.last != want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("word mismatch\n  expected %p\n  actual   %p", want, got);
				end
			end
		end
	end

	// Watchdog: too long without any word moving on either channel.
	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Directed table: a list opened and closed at offset 0, the integer zero,
	// a dictionary with a string key and a negative value, a string with a
	// zero-padded length, and an empty string. Rows with a typed word are
	// checked against it; the others against the behavioral parser.
	// ------------------------------------------------------------------------
	typedef struct {
		logic [7:0]       b;
		bit               typed;
		bst_pkg::result_t want;
	} dir_row_t;

	dir_row_t dir_table[21];

	initial begin
		bst_pkg::result_t w[2];
		int      n;
		int      total;
		string   plain;

		arst_n = 1'b0;
		parser_reset();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		dir_table[0] = '{bst_pkg::CH_L, 1, mk(bst_pkg::EV_OPEN, bst_pkg::TY_LIST, 0, 0, 1,
			0, 0, 0, bst_pkg::ERR_NONE, 0, 1)};
		dir_table[1] = '{bst_pkg::CH_E, 1, mk(bst_pkg::EV_DONE, bst_pkg::TY_LIST, 0, 0, 1,
			2, 0, 0, bst_pkg::ERR_NONE, 0, 1)};
		dir_table[2] = '{bst_pkg::CH_I, 0, '0};
		dir_table[3] = '{bst_pkg::CH_ZERO, 0, '0};
		dir_table[4] = '{bst_pkg::CH_E, 1, mk(bst_pkg::EV_DONE, bst_pkg::TY_INT, 0, 2, 3,
			3, 1, 0, bst_pkg::ERR_NONE, 0, 1)};
		plain = "d1:ki-5ee02:xy0:";
		for (int k = 0; k < plain.len(); k++) dir_table[5 + k] = '{plain[k], 0, '0};

		foreach (dir_table[k]) begin
			send_byte(dir_table[k].b);
			parse_byte(dir_table[k].b, w, n);
			if (dir_table[k].typed) pending_words = {pending_words, dir_table[k].want};
			else expect_words(w, n);
		end

		// Random documents, then the closing fault.
		while (doc_bytes.size() < STREAM_BYTES)
			gen_value(0, $urandom_range(0, 19) == 0);
		gen_fault();

		// Four idling phases: none, sender slow, receiver slow, both.
		total = doc_bytes.size();
		for (int k = 0; k < total; k++) begin
			case (k * 4 / total)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			send_byte(doc_bytes[k]);
			parse_byte(doc_bytes[k], w, n);
			expect_words(w, n);
		end
		@(negedge clk);
		src_valid <= 1'b0;

		while (pending_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
